// ===== rtl/crt_pkg.sv =====
// ============================================================================
// crt_pkg - shared types and codes for the compacting record table
// Beat layouts for the command and response channels, the stored record,
// action and status codes, and the sequencer state encoding.
// ============================================================================
`default_nettype none

package crt_pkg;

  // Action codes carried by a command beat
  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_LIST   = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;

  // Status codes carried by a response beat
  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_LISTED    = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_REMOVED   = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

  // Command beat
  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] record_id;
    logic signed [31:0] record_kind;
    logic [63:0]        message_word;
  } cmd_t;

  // Response beat
  typedef struct packed {
    logic [2:0]         status;
    logic [4:0]         position;
    logic signed [31:0] out_id;
    logic signed [31:0] out_kind;
    logic [63:0]        out_message;
    logic               last;
  } rsp_t;

  // One table slot
  typedef struct packed {
    logic [31:0] id;
    logic [31:0] kind;
    logic [63:0] msg;
  } rec_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_LIST_RD,
    S_LIST_OUT,
    S_SEARCH_RD,
    S_SEARCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_RESULT
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/compacting_record_table.sv =====
// ============================================================================
// compacting_record_table - fixed-capacity record table with compaction
// Appends records at the tail, lists them in slot order, and deletes the
// first record with a matching id by moving later records down one slot.
// ============================================================================
//
//  channel | direction | handshake            | beat
//  --------+-----------+----------------------+------------------------------
//  cmd     | in        | cmd_valid / cmd_stall | action, id, kind, message
//  rsp     | out       | rsp_valid / rsp_stall | status, position, record, last
//
//  Add writes the new tail slot unless the table is full, then replies. List
//  reads each stored record and sends it as a beat. Delete reads and compares
//  slots in turn until a match, then moves each later record one slot down,
//  then replies. The slot memory has one read port, one write port and a registered read.
//  Reset empties the table at once; no clearing pass. cmd_stall is high while
//  a command is in progress; rsp_stall holds the list and result states.
`default_nettype none

module compacting_record_table #(
  parameter int CAPACITY  = 16,
  parameter int MSG_CHARS = 8
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                cmd_valid,
  output logic               cmd_stall,
  input  wire crt_pkg::cmd_t cmd,
  output logic               rsp_valid,
  input  wire                rsp_stall,
  output crt_pkg::rsp_t      rsp
);

  import crt_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [63:0] MSG_MASK = {64{1'b1}} >> (64 - 8 * MSG_CHARS);

  // Registers
  state_t            state, state_next;
  cmd_t              cmd_q;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  idx, idx_next;
  logic [2:0]        status, status_next;
  rec_t              rd_data;
  rec_t              mem [CAPACITY];
  rsp_t              rsp_next;

  // Control from the sequencer
  logic              cmd_load;
  logic              push;
  logic              mem_we;
  logic [IDX_W-1:0]  wr_addr;
  rec_t              wr_data;

  // Helpers
  logic              accept;
  logic              out_free;
  logic [CNT_W-1:0]  idx_inc;
  logic [CNT_W-1:0]  idx_dec;
  logic [CNT_W:0]    idx_plus;
  logic              idx_last;
  logic              id_match;
  logic              table_full;

  assign cmd_stall  = (state != S_IDLE);
  assign accept     = cmd_valid && !cmd_stall;
  assign out_free   = !rsp_valid || !rsp_stall;
  assign idx_inc    = idx + CNT_W'(1);
  assign idx_dec    = idx - CNT_W'(1);
  assign idx_plus   = {1'b0, idx} + (CNT_W + 1)'(1);
  assign idx_last   = (idx_plus == {1'b0, count});
  assign id_match   = (rd_data.id == cmd_q.record_id);
  assign table_full = (count >= CNT_W'(CAPACITY));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd.action)
            ACT_ADD:    state_next = S_ADD;
            ACT_LIST:   state_next = (count == '0) ? S_RESULT : S_LIST_RD;
            ACT_DELETE: state_next = (count == '0) ? S_RESULT : S_SEARCH_RD;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_ADD:       state_next = S_RESULT;
      S_LIST_RD:   state_next = S_LIST_OUT;
      S_LIST_OUT: begin
        if (out_free) begin
          state_next = idx_last ? S_IDLE : S_LIST_RD;
        end
      end
      S_SEARCH_RD: state_next = S_SEARCH_CMP;
      S_SEARCH_CMP: begin
        if (idx_last) begin
          state_next = S_RESULT;
        end else if (id_match) begin
          state_next = S_SHIFT_RD;
        end else begin
          state_next = S_SEARCH_RD;
        end
      end
      S_SHIFT_RD:  state_next = S_SHIFT_WR;
      S_SHIFT_WR:  state_next = idx_last ? S_RESULT : S_SHIFT_RD;
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:     state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs and datapath updates
  always_comb begin
    cmd_load    = 1'b0;
    push        = 1'b0;
    mem_we      = 1'b0;
    wr_addr     = idx[IDX_W-1:0];
    wr_data     = rd_data;
    idx_next    = idx;
    count_next  = count;
    status_next = status;
    rsp_next    = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd_load    = 1'b1;
          idx_next    = '0;
          status_next = (cmd.action == ACT_LIST) ? ST_EMPTY : ST_NOT_FOUND;
        end
      end
      S_ADD: begin
        if (table_full) begin
          status_next = ST_FULL;
        end else begin
          mem_we       = 1'b1;
          wr_addr      = count[IDX_W-1:0];
          wr_data.id   = cmd_q.record_id;
          wr_data.kind = cmd_q.record_kind;
          wr_data.msg  = cmd_q.message_word & MSG_MASK;
          count_next   = count + CNT_W'(1);
          status_next  = ST_ADDED;
        end
      end
      S_LIST_OUT: begin
        if (out_free) begin
          push                 = 1'b1;
          rsp_next.status      = ST_LISTED;
          rsp_next.position    = 5'(idx_plus);
          rsp_next.out_id      = rd_data.id;
          rsp_next.out_kind    = rd_data.kind;
          rsp_next.out_message = rd_data.msg;
          rsp_next.last        = idx_last;
          idx_next             = idx_inc;
        end
      end
      S_SEARCH_CMP: begin
        if (id_match && idx_last) begin
          // match in the tail slot: nothing to move
          count_next  = count - CNT_W'(1);
          status_next = ST_REMOVED;
        end else if (!idx_last) begin
          idx_next = idx_inc;
        end
      end
      S_SHIFT_WR: begin
        // move the record just read down one slot
        mem_we  = 1'b1;
        wr_addr = idx_dec[IDX_W-1:0];
        wr_data = rd_data;
        if (idx_last) begin
          count_next  = count - CNT_W'(1);
          status_next = ST_REMOVED;
        end else begin
          idx_next = idx_inc;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          push            = 1'b1;
          rsp_next.status = status;
          rsp_next.last   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Slot memory: one write port, registered read at the walk index
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[idx[IDX_W-1:0]];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (push) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx    <= idx_next;
    status <= status_next;
    if (cmd_load) begin
      cmd_q <= cmd;
    end
    if (push) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

// ===== tb/record_table_checker.sv =====
// ----------------------------------------------------------------------------
// record_table_checker - response checker for the compacting record table
// Watches both channels. Each accepted command updates a local copy of the
// table and queues the replies it should produce. Each accepted response
// beat is compared field by field against the oldest queued reply.
// ----------------------------------------------------------------------------
module record_table_checker #(
  parameter int CAPACITY  = 16,
  parameter int MSG_CHARS = 8
) (
  input  wire           clk,
  input  wire           rst,
  input  wire           cmd_valid,
  input  wire           cmd_stall,
  input  crt_pkg::cmd_t cmd,
  input  wire           rsp_valid,
  input  wire           rsp_stall,
  input  crt_pkg::rsp_t rsp,
  output int            errors,
  output int            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import crt_pkg::*;

  localparam logic [63:0] MSG_MASK = {64{1'b1}} >> (64 - 8 * MSG_CHARS);

  // local copy of the table
  rec_t slots [CAPACITY];
  int   filled = 0;

  // replies owed by the block, oldest first
  rsp_t replies [$];
  int   err_count = 0;

  function automatic rsp_t status_reply(input logic [2:0] code);
    rsp_t r;
    r = '0;
    r.status = code;
    r.last = 1'b1;
    return r;
  endfunction

  // apply one command to the table copy and queue its replies
  task automatic apply_command(input cmd_t c);
    rsp_t r;
    int   hit;
    hit = -1;
    case (c.action)
      ACT_ADD: begin
        if (filled == CAPACITY) begin
          replies.push_back(status_reply(ST_FULL));
        end else begin
          slots[filled] = '{id: c.record_id, kind: c.record_kind,
                            msg: c.message_word & MSG_MASK};
          filled++;
          replies.push_back(status_reply(ST_ADDED));
        end
      end
      ACT_LIST: begin
        if (filled == 0) replies.push_back(status_reply(ST_EMPTY));
        for (int i = 0; i < filled; i++) begin
          r = '0;
          r.status      = ST_LISTED;
          r.position    = 5'(i + 1);
          r.out_id      = slots[i].id;
          r.out_kind    = slots[i].kind;
          r.out_message = slots[i].msg;
          r.last        = (i + 1 == filled);
          replies.push_back(r);
        end
      end
      ACT_DELETE: begin
        // lowest matching slot wins on duplicate ids
        for (int i = 0; i < filled; i++)
          if (hit < 0 && slots[i].id == c.record_id) hit = i;
        if (hit < 0) begin
          replies.push_back(status_reply(ST_NOT_FOUND));
        end else begin
          for (int j = hit; j + 1 < filled; j++) slots[j] = slots[j + 1];
          filled--;
          replies.push_back(status_reply(ST_REMOVED));
        end
      end
      default: ; // unused action code: no reply, table unchanged
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      err_count++;
    end
  endtask

  // response check first: a reply never belongs to a command taken this edge
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      filled = 0;
      replies.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (replies.size() == 0) begin
          $display("%0t: unexpected beat: expected none, got status %0d id %h",
                   $time, rsp.status, rsp.out_id);
          err_count++;
        end else begin
          want = replies.pop_front();
          check_field("status", 64'(want.status), 64'(rsp.status));
          check_field("position", 64'(want.position), 64'(rsp.position));
          check_field("out_id", 64'(want.out_id), 64'(rsp.out_id));
          check_field("out_kind", 64'(want.out_kind), 64'(rsp.out_kind));
          check_field("out_message", want.out_message, rsp.out_message);
          check_field("last", 64'(want.last), 64'(rsp.last));
        end
      end
      if (cmd_valid && !cmd_stall) apply_command(cmd);
    end
    errors  <= err_count;
    pending <= replies.size();
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - stimulus for the compacting record table
// Runs a directed pass over empty, full, duplicate-id and unused-code cases,
// then random add/list/delete traffic drawn from a small id pool so deletes
// hit often. Both sides idle at random; the receiver also holds off once for
// a long stretch so the block backs up into its command channel.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import crt_pkg::*;

  localparam int         CAPACITY     = 16;
  localparam int         MSG_CHARS    = 8;
  localparam int         RANDOM_ITEMS = 140;
  localparam int         HOLD_CYCLES  = 400;
  localparam int         CYCLE_LIMIT  = 200000;
  localparam logic [1:0] ACT_UNUSED   = 2'd3;

  logic clk = 1'b0;
  logic rst;
  logic cmd_valid;
  logic cmd_stall;
  cmd_t cmd;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  int errors;
  int pending;
  int idle_pct = 38;
  int holds_asked = 0;
  int holds_granted = 0;
  int hold_left = 0;
  int cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  compacting_record_table #(
    .CAPACITY  (CAPACITY),
    .MSG_CHARS (MSG_CHARS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  record_table_checker #(
    .CAPACITY  (CAPACITY),
    .MSG_CHARS (MSG_CHARS)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .errors    (errors),
    .pending   (pending)
  );

  function automatic cmd_t make_cmd(input logic [1:0] act, input logic [31:0] id,
                                    input logic [31:0] kind, input logic [63:0] msg);
    cmd_t c;
    c.action       = act;
    c.record_id    = id;
    c.record_kind  = kind;
    c.message_word = msg;
    return c;
  endfunction

  // ids mostly from a small pool (extremes included) so deletes find matches
  function automatic cmd_t random_command(input bit add_heavy);
    cmd_t        c;
    int unsigned roll;
    roll = $urandom_range(99);
    c.record_kind  = $urandom;
    c.message_word = {$urandom, $urandom};
    if ($urandom_range(99) < 85) begin
      case ($urandom_range(7))
        0: c.record_id = 32'h8000_0000;
        1: c.record_id = 32'h7fff_ffff;
        2: c.record_id = 32'h0;
        3: c.record_id = 32'hffff_ffff;
        4: c.record_id = 32'h1;
        5: c.record_id = 32'h5;
        6: c.record_id = 32'h2a;
        default: c.record_id = 32'h3e8;
      endcase
    end else begin
      c.record_id = $urandom;
    end
    if (roll < 5) c.action = 2'($urandom_range(3));
    else if (roll < 20) c.action = ACT_LIST;
    else if (roll < (add_heavy ? 80 : 40)) c.action = ACT_ADD;
    else c.action = ACT_DELETE;
    return c;
  endfunction

  // offer one beat, with random idle cycles ahead of it; returns on acceptance
  task automatic send(input cmd_t c);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
  endtask

  // response side: random stalls, plus long hold-offs on request
  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else if (holds_granted != holds_asked) begin
        holds_granted++;
        hold_left = HOLD_CYCLES - 1;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(99) < idle_pct);
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("compacting_record_table verification failed");
    $finish;
  end

  initial begin
    cmd_t c;
    int   counted;
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty table cases and the unused action code
    send(make_cmd(ACT_LIST, 32'h0, 32'h0, 64'h0));
    send(make_cmd(ACT_DELETE, 32'h7, 32'h0, 64'h0));
    send(make_cmd(ACT_UNUSED, 32'hffff_ffff, 32'hffff_ffff, {64{1'b1}}));

    // field extremes, then a duplicate id
    send(make_cmd(ACT_ADD, 32'h8000_0000, 32'h7fff_ffff, {64{1'b1}}));
    send(make_cmd(ACT_ADD, 32'h7fff_ffff, 32'h8000_0000, 64'h0));
    send(make_cmd(ACT_ADD, 32'h5, 32'hffff_ffff, 64'h0123_4567_89ab_cdef));
    send(make_cmd(ACT_ADD, 32'h5, 32'h1, 64'h4f4b));
    send(make_cmd(ACT_LIST, 32'h0, 32'h0, 64'h0));

    // duplicate delete takes the lower slot; missing id is not found
    send(make_cmd(ACT_DELETE, 32'h5, 32'h0, 64'h0));
    send(make_cmd(ACT_DELETE, 32'h3039, 32'h0, 64'h0));
    send(make_cmd(ACT_LIST, 32'h0, 32'h0, 64'h0));

    // fill to capacity, then one add too many
    for (int k = 0; k < CAPACITY - 3; k++)
      send(make_cmd(ACT_ADD, 32'(200 + k), $urandom, {$urandom, $urandom}));
    send(make_cmd(ACT_ADD, 32'h63, 32'h63, 64'h63));
    send(make_cmd(ACT_LIST, 32'h0, 32'h0, 64'h0));

    // delete head and tail of a full table
    send(make_cmd(ACT_DELETE, 32'h8000_0000, 32'h0, 64'h0));
    send(make_cmd(ACT_DELETE, 32'(200 + CAPACITY - 4), 32'h0, 64'h0));
    send(make_cmd(ACT_LIST, 32'h0, 32'h0, 64'h0));

    // random traffic, alternating delete-heavy and add-heavy stretches
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      idle_pct = (counted >= 90 && counted < 130) ? 0 : 38;
      if (counted == 30 && holds_asked == 0) holds_asked++;
      c = random_command(((counted / 30) % 2) == 1);
      send(c);
      if (c.action != ACT_UNUSED) counted++;
    end

    @(negedge clk);
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    if (errors == 0 && pending == 0)
      $display("compacting_record_table verification clean");
    else
      $display("compacting_record_table verification failed");
    $finish;
  end

endmodule
